>>> rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and codes for the countdown timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS_DEF     = 8;
  localparam int TICK_PERIOD_MS_DEF = 10;
  localparam int CNT_W              = 13;
  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

  localparam logic [2:0] K_TICK    = 3'd0;
  localparam logic [2:0] K_CREATE  = 3'd1;
  localparam logic [2:0] K_DESTROY = 3'd2;
  localparam logic [2:0] K_EVAL    = 3'd3;
  localparam logic [2:0] K_RESTART = 3'd4;
  localparam logic [2:0] K_STOP    = 3'd5;
  localparam logic [2:0] K_FORCE   = 3'd6;
  localparam logic [2:0] K_CONT    = 3'd7;

  localparam logic [1:0] M_STOPPED = 2'd0;
  localparam logic [1:0] M_RUNNING = 2'd1;
  localparam logic [1:0] M_EXPIRED = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;
  localparam logic [1:0] ST_BAD_STATE = 2'd3;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       target_id;
    logic [CNT_W-1:0] load;
    logic [1:0]       start_mode;
    logic             restart_flag;
  } cmd_t;

  // result item: kind, status, handle, count, last
  typedef struct packed {
    logic       result_kind;
    logic [1:0] status;
    logic [2:0] handle;
    logic [3:0] count;
    logic       last;
  } res_t;

endpackage

>>> rtl/core/stb_front.sv
// ----------------------------------------------------------------------------
// stb_front
// accepts commands, scales the create duration to ticks, two-entry queue
// ----------------------------------------------------------------------------
module stb_front #(
  parameter int TICK_PERIOD_MS = stb_pkg::TICK_PERIOD_MS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    kind,
  input  logic [7:0]    target_id,
  input  logic [15:0]   duration_ms,
  input  logic [1:0]    start_mode,
  input  logic          restart_flag,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output stb_pkg::cmd_t cmd
);

  // reciprocal for duration / period, exact for 16-bit dividends
  localparam int SH = 32;
  localparam longint RECIP = ((64'd1 << SH) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;

  stb_pkg::cmd_t q0, q1, enq;
  logic          v0, v1;
  logic [48:0]   prod;
  logic [16:0]   quo;

  always_comb begin
    prod = 49'(duration_ms) * 49'(RECIP[32:0]);
    quo  = 17'(prod >> SH);
    enq.kind         = kind;
    enq.target_id    = target_id;
    enq.load         = (quo > 17'(stb_pkg::COUNT_MAX)) ? stb_pkg::COUNT_MAX
                                                      : quo[stb_pkg::CNT_W-1:0];
    enq.start_mode   = (start_mode == 2'd3) ? stb_pkg::M_STOPPED : start_mode;
    enq.restart_flag = restart_flag;
  end

  assign in_ready  = !v1;
  assign cmd_valid = v0;
  assign cmd       = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      logic push, pop;
      push = in_valid && in_ready;
      pop  = cmd_valid && cmd_ready;
      if (pop) begin
        if (v1) begin
          q0 <= q1;
          v1 <= push;
          if (push) q1 <= enq;
        end else begin
          v0 <= push;
          if (push) q0 <= enq;
        end
      end else if (push) begin
        if (!v0) begin
          q0 <= enq;
          v0 <= 1'b1;
        end else begin
          q1 <= enq;
          v1 <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/stb_back.sv
// ----------------------------------------------------------------------------
// stb_back
// executes commands on the timer table, walks slots for tick and evaluate
// ----------------------------------------------------------------------------
module stb_back #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  stb_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output stb_pkg::res_t res
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int NW = $clog2(NUM_TIMERS + 1);
  localparam int CW = stb_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [NUM_TIMERS-1:0] in_use, auto_reload;
  logic [1:0]    mode   [NUM_TIMERS];
  logic [CW-1:0] reload [NUM_TIMERS];
  logic [CW-1:0] cur    [NUM_TIMERS];
  logic [NW-1:0] created_total, active;
  logic          tick_pending;
  logic [1:0]    state;
  logic [IW-1:0] idx;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic [IW-1:0] tid;
  logic          id_ok;
  logic          slot_last;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign id_ok     = cmd.target_id < 8'(NUM_TIMERS);
  assign tid       = cmd.target_id[IW-1:0];
  assign slot_last = idx == IW'(NUM_TIMERS - 1);
  assign cmd_ready = (state == S_IDLE) && !res_valid;

  function automatic stb_pkg::res_t mk(logic rk, logic [1:0] st, logic [2:0] h,
                                       logic [3:0] c, logic l);
    stb_pkg::res_t r;
    r.result_kind = rk;
    r.status      = st;
    r.handle      = h;
    r.count       = c;
    r.last        = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use        <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) mode[i] <= stb_pkg::M_STOPPED;
      created_total <= '0;
      tick_pending  <= 1'b0;
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      idx           <= '0;
      active        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            case (cmd.kind)
              stb_pkg::K_TICK: begin
                tick_pending <= 1'b1;
                idx   <= '0;
                state <= S_TICK;
              end
              stb_pkg::K_CREATE: begin
                res_valid <= 1'b1;
                if (created_total < NW'(NUM_TIMERS) && free_found) begin
                  reload[free_idx]      <= cmd.load;
                  cur[free_idx]         <= cmd.load;
                  auto_reload[free_idx] <= cmd.restart_flag;
                  mode[free_idx]        <= cmd.start_mode;
                  in_use[free_idx]      <= 1'b1;
                  created_total         <= created_total + 1'b1;
                  res <= mk(1'b0, stb_pkg::ST_OK, 3'(free_idx), 4'd0, 1'b1);
                end else begin
                  res <= mk(1'b0, stb_pkg::ST_FULL, 3'd0, 4'd0, 1'b1);
                end
              end
              stb_pkg::K_EVAL: begin
                idx    <= '0;
                active <= '0;
                if (tick_pending) begin
                  state <= S_EVAL;
                end else begin
                  res_valid <= 1'b1;
                  res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
                end
              end
              default: begin
                res_valid <= 1'b1;
                if (!id_ok) begin
                  res <= mk(1'b0, stb_pkg::ST_BAD_ID, 3'd0, 4'd0, 1'b1);
                end else if (!in_use[tid]) begin
                  res <= mk(1'b0, stb_pkg::ST_BAD_STATE, 3'd0, 4'd0, 1'b1);
                end else begin
                  case (cmd.kind)
                    stb_pkg::K_DESTROY: begin
                      mode[tid]   <= stb_pkg::M_STOPPED;
                      in_use[tid] <= 1'b0;
                      created_total <= (created_total != '0) ? created_total - 1'b1
                                                             : created_total;
                      res <= mk(1'b0, stb_pkg::ST_OK, 3'd0,
                                4'((created_total != '0) ? created_total - 1'b1 : '0),
                                1'b1);
                    end
                    stb_pkg::K_RESTART: begin
                      mode[tid] <= stb_pkg::M_RUNNING;
                      cur[tid]  <= reload[tid];
                      res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
                    end
                    stb_pkg::K_STOP: begin
                      mode[tid] <= stb_pkg::M_STOPPED;
                      res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
                    end
                    stb_pkg::K_FORCE: begin
                      cur[tid]  <= '0;
                      mode[tid] <= stb_pkg::M_EXPIRED;
                      res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
                    end
                    default: begin
                      if (mode[tid] != stb_pkg::M_STOPPED) begin
                        res <= mk(1'b0, stb_pkg::ST_BAD_STATE, 3'd0, 4'd0, 1'b1);
                      end else begin
                        mode[tid] <= stb_pkg::M_RUNNING;
                        res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
                      end
                    end
                  endcase
                end
              end
            endcase
          end else if (res_ready) begin
            res_valid <= 1'b0;
          end
        end
        S_TICK: begin
          if (in_use[idx] && mode[idx] == stb_pkg::M_RUNNING) begin
            if (cur[idx] <= CW'(1)) begin
              cur[idx]  <= '0;
              mode[idx] <= stb_pkg::M_EXPIRED;
            end else begin
              cur[idx] <= cur[idx] - 1'b1;
            end
          end
          idx <= idx + 1'b1;
          if (slot_last) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
            res <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1);
          end
        end
        S_EVAL: begin
          // one slot per cycle, stalls while a notice is waiting
          if (!res_valid || res_ready) begin
            if (in_use[idx] && mode[idx] == stb_pkg::M_EXPIRED) begin
              res_valid <= 1'b1;
              res <= mk(1'b1, stb_pkg::ST_OK, 3'(idx), 4'd0, 1'b0);
              if (auto_reload[idx]) begin
                cur[idx]  <= reload[idx];
                mode[idx] <= stb_pkg::M_RUNNING;
                active    <= active + 1'b1;
              end else begin
                mode[idx] <= stb_pkg::M_STOPPED;
              end
            end else begin
              res_valid <= 1'b0;
              if (in_use[idx] && mode[idx] == stb_pkg::M_RUNNING) begin
                active <= active + 1'b1;
              end
            end
            idx <= idx + 1'b1;
            if (slot_last) state <= S_DONE;
          end
        end
        S_DONE: begin
          // final reply of evaluate
          if (!res_valid || res_ready) begin
            tick_pending <= 1'b0;
            res_valid    <= 1'b1;
            res   <= mk(1'b0, stb_pkg::ST_OK, 3'd0, 4'(active), 1'b1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// bank of countdown timers driven by a command stream
// ----------------------------------------------------------------------------
// Commands enter a two-deep queue and are executed one at a time. Create,
// destroy, restart, stop, force and continue execute directly and then hand
// their reply to the output; tick walks every slot, one per cycle, then
// replies; evaluate, when a tick is pending, walks the slots the same way,
// pausing while a notice waits on the output, and ends with its reply; with
// no tick pending it replies without a walk. Every command ends with
// one reply with tlast high; expiry notices come before it with tlast low.
module software_timer_bank #(
  parameter int NUM_TIMERS     = stb_pkg::NUM_TIMERS_DEF,
  parameter int TICK_PERIOD_MS = stb_pkg::TICK_PERIOD_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // target_id, duration_ms, start_mode, restart_flag
  input  logic [2:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // status, handle, count
  output logic        m_tuser,  // result_kind
  output logic        m_tlast
);

  logic          cmd_valid, cmd_ready;
  stb_pkg::cmd_t cmd;
  stb_pkg::res_t res;

  stb_front #(.TICK_PERIOD_MS(TICK_PERIOD_MS)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .kind(s_tuser), .target_id(s_tdata[7:0]), .duration_ms(s_tdata[23:8]),
    .start_mode(s_tdata[25:24]), .restart_flag(s_tdata[26]),
    .cmd_valid, .cmd_ready, .cmd
  );

  stb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_tvalid), .res_ready(m_tready), .res
  );

  assign m_tdata = {7'd0, res.count, res.handle, res.status};
  assign m_tuser = res.result_kind;
  assign m_tlast = res.last;

endmodule

>>> rtl/core/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// port-level checks on the timer bank result stream
// ----------------------------------------------------------------------------
module stb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_notice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast && m_tdata[1:0] == 2'd0 && m_tdata[8:5] == 4'd0)
    else $error("malformed expiry notice");

  a_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("reply without tlast");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'd0)
    else $error("padding bit set");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

>>> tb/sv/software_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// software_timer_bank_tb
// command stream checker for the countdown timer bank: directed commands
// then random lifecycles, with a local model of the bank predicting replies
// and expiry notices
// ----------------------------------------------------------------------------
module software_timer_bank_tb;

  localparam int NT = 8;
  localparam int TP = 10;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  target_id;
    logic [15:0] duration_ms;
    logic [1:0]  start_mode;
    logic        restart_flag;
  } cmd_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // transaction accepted at the last rising edge
  logic s_tready_seen = 1'b0;

  software_timer_bank u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // bank model
  logic                      bk_in_use [NT];
  logic [1:0]                bk_mode [NT];
  logic [stb_pkg::CNT_W-1:0] bk_reload [NT];
  logic [stb_pkg::CNT_W-1:0] bk_cur [NT];
  logic                      bk_auto [NT];
  int                        bk_created;
  logic                      bk_tick_pending;

  cmd_item_t     cmd_queue[$];
  stb_pkg::res_t expected_results[$];
  int            errors = 0;
  int            cycle = 0;
  bit            all_sent = 1'b0;
  bit            hold_rx = 1'b0;
  bit            quiet = 1'b0;

  function automatic stb_pkg::res_t mk_res(logic rk, logic [1:0] st, logic [2:0] h,
                                           logic [3:0] c, logic l);
    stb_pkg::res_t r;
    r.result_kind = rk; r.status = st; r.handle = h; r.count = c; r.last = l;
    return r;
  endfunction

  task automatic predict_command(cmd_item_t c);
    int active;
    int q;
    int s;
    bit found;
    active = 0;
    found = 1'b0;
    case (c.kind)
      stb_pkg::K_TICK: begin
        bk_tick_pending = 1'b1;
        for (int i = 0; i < NT; i++)
          if (bk_in_use[i] && bk_mode[i] == stb_pkg::M_RUNNING) begin
            if (bk_cur[i] > 0) bk_cur[i]--;
            if (bk_cur[i] == 0) bk_mode[i] = stb_pkg::M_EXPIRED;
          end
        expected_results.push_back(mk_res(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1));
      end
      stb_pkg::K_CREATE: begin
        if (bk_created < NT)
          for (int i = 0; i < NT && !found; i++)
            if (!bk_in_use[i]) begin
              q = c.duration_ms / TP;
              if (q > stb_pkg::COUNT_MAX) q = stb_pkg::COUNT_MAX;
              bk_reload[i] = stb_pkg::CNT_W'(q);
              bk_cur[i] = stb_pkg::CNT_W'(q);
              bk_auto[i] = c.restart_flag;
              bk_mode[i] = (c.start_mode == 2'd3) ? stb_pkg::M_STOPPED : c.start_mode;
              bk_in_use[i] = 1'b1;
              bk_created++;
              expected_results.push_back(mk_res(1'b0, stb_pkg::ST_OK, 3'(i), 4'd0, 1'b1));
              found = 1'b1;
            end
        if (!found)
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_FULL, 3'd0, 4'd0, 1'b1));
      end
      stb_pkg::K_EVAL: begin
        if (bk_tick_pending)
          for (int i = 0; i < NT; i++)
            if (bk_in_use[i]) begin
              if (bk_mode[i] == stb_pkg::M_RUNNING) active++;
              else if (bk_mode[i] == stb_pkg::M_EXPIRED) begin
                expected_results.push_back(mk_res(1'b1, stb_pkg::ST_OK, 3'(i), 4'd0, 1'b0));
                if (bk_auto[i]) begin
                  bk_cur[i] = bk_reload[i];
                  bk_mode[i] = stb_pkg::M_RUNNING;
                  active++;
                end else bk_mode[i] = stb_pkg::M_STOPPED;
              end
            end
        bk_tick_pending = 1'b0;
        expected_results.push_back(mk_res(1'b0, stb_pkg::ST_OK, 3'd0, 4'(active), 1'b1));
      end
      default: begin
        s = c.target_id;
        if (c.target_id >= NT)
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_BAD_ID, 3'd0, 4'd0, 1'b1));
        else if (!bk_in_use[s])
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_BAD_STATE, 3'd0, 4'd0, 1'b1));
        else if (c.kind == stb_pkg::K_DESTROY) begin
          bk_mode[s] = stb_pkg::M_STOPPED;
          bk_in_use[s] = 1'b0;
          if (bk_created > 0) bk_created--;
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_OK, 3'd0, 4'(bk_created),
                                            1'b1));
        end else if (c.kind == stb_pkg::K_CONT && bk_mode[s] != stb_pkg::M_STOPPED)
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_BAD_STATE, 3'd0, 4'd0, 1'b1));
        else begin
          case (c.kind)
            stb_pkg::K_RESTART: begin
              bk_mode[s] = stb_pkg::M_RUNNING; bk_cur[s] = bk_reload[s];
            end
            stb_pkg::K_STOP:  bk_mode[s] = stb_pkg::M_STOPPED;
            stb_pkg::K_FORCE: begin bk_cur[s] = 0; bk_mode[s] = stb_pkg::M_EXPIRED; end
            default:          bk_mode[s] = stb_pkg::M_RUNNING;
          endcase
          expected_results.push_back(mk_res(1'b0, stb_pkg::ST_OK, 3'd0, 4'd0, 1'b1));
        end
      end
    endcase
  endtask

  function automatic cmd_item_t mk_cmd(logic [2:0] k, logic [7:0] id,
                                       logic [15:0] d, logic [1:0] sm, logic rf);
    cmd_item_t c;
    c.kind = k; c.target_id = id; c.duration_ms = d; c.start_mode = sm;
    c.restart_flag = rf;
    return c;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_seen) begin
        if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
          s_tvalid <= 1'b1;
          s_tuser  <= cmd_queue[0].kind;
          s_tdata  <= {5'd0, cmd_queue[0].restart_flag, cmd_queue[0].start_mode,
                       cmd_queue[0].duration_ms, cmd_queue[0].target_id};
          predict_command(cmd_queue.pop_front());
        end else s_tvalid <= 1'b0;
      end
      m_tready <= !hold_rx && (quiet || $urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) s_tready_seen <= s_tvalid && s_tready;

  // monitor
  always @(posedge clk) begin
    stb_pkg::res_t e;
    cycle <= cycle + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result tdata=%h tuser=%b tlast=%b", m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_tuser !== e.result_kind) begin
          $error("result_kind expected %0d actual %0d", e.result_kind, m_tuser); errors++;
        end
        if (m_tdata[1:0] !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_tdata[1:0]); errors++;
        end
        if (m_tdata[4:2] !== e.handle) begin
          $error("handle expected %0d actual %0d", e.handle, m_tdata[4:2]); errors++;
        end
        if (m_tdata[8:5] !== e.count) begin
          $error("count expected %0d actual %0d", e.count, m_tdata[8:5]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last expected %0d actual %0d", e.last, m_tlast); errors++;
        end
      end
    end
    if (cycle > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    for (int i = 0; i < NT; i++) begin
      bk_in_use[i] = 0; bk_mode[i] = stb_pkg::M_STOPPED; bk_reload[i] = 0; bk_cur[i] = 0;
      bk_auto[i] = 0;
    end
    bk_created = 0;
    bk_tick_pending = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-bank cases, then fill the bank and exercise each command
    cmd_queue.push_back(mk_cmd(stb_pkg::K_EVAL, 0, 0, 0, 0));      // no tick pending
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CONT, 0, 0, 0, 0));      // not created
    cmd_queue.push_back(mk_cmd(stb_pkg::K_STOP, 8'hFF, 0, 0, 0));  // invalid id
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 16'hFFFF, 1, 1)); // largest duration, still below COUNT_MAX
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 8'hFF, 0, 1, 0));    // zero duration
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 25, 3, 1));       // start mode three
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 10, 2, 1));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 30, 1, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 9, 0, 1));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 20, 1, 1));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 15, 1, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CREATE, 0, 40, 1, 0));  // bank full
    cmd_queue.push_back(mk_cmd(stb_pkg::K_TICK, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CONT, 2, 0, 0, 0));     // continue a stopped timer
    cmd_queue.push_back(mk_cmd(stb_pkg::K_CONT, 2, 0, 0, 0));     // not stopped any more
    cmd_queue.push_back(mk_cmd(stb_pkg::K_FORCE, 7, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_EVAL, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_RESTART, 3, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_DESTROY, 4, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_DESTROY, 4, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_STOP, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_TICK, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(stb_pkg::K_EVAL, 0, 0, 0, 0));

    // random: mostly valid ids and short durations so timers expire often
    for (int i = 0; i < 500; i++) begin
      r = $urandom_range(99);
      n = (r < 25) ? stb_pkg::K_TICK : (r < 40) ? stb_pkg::K_EVAL :
          (r < 55) ? stb_pkg::K_CREATE : $urandom_range(7);
      cmd_queue.push_back(mk_cmd(3'(n),
        8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(NT - 1)),
        16'(($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(60)),
        2'($urandom_range(3)), 1'($urandom_range(1))));
    end

    // long receiver hold-off so the block backs up
    repeat (100) @(posedge clk);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
    quiet = 1'b1;
    repeat (2000) @(posedge clk);
    quiet = 1'b0;

    wait (cmd_queue.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/stb_pkg.sv
rtl/core/stb_front.sv
rtl/core/stb_back.sv
rtl/core/software_timer_bank.sv
rtl/core/stb_checker.sv
tb/sv/software_timer_bank_tb.sv
